>>> rtl/touch_sample_qualifier_unit_assert.svh
// Assertion macros for the touch sample qualifier.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef TOUCH_SAMPLE_QUALIFIER_UNIT_ASSERT_SVH
`define TOUCH_SAMPLE_QUALIFIER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define TSQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSQ_ASSERT_IMP(name, ante, cons, msg)
`define TSQ_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

>>> rtl/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

  // Field widths
  localparam int unsigned SampleW  = 12;
  localparam int unsigned PosW     = 13;
  localparam int unsigned RadiusW  = 6;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam int unsigned SamplesPerPointDef = 3;

  // Register reset values
  localparam logic                MeasureEnRst   = 1'b1;
  localparam logic [SampleW-1:0]  SpreadLimitRst = 12'd250;
  localparam logic [RadiusW-1:0]  JumpRadiusRst  = 6'd20;
  localparam logic [OffsetW-1:0]  EdgeOffsetRst  = 10'd250;

  // Flip base for y and grace count
  localparam logic [PosW-1:0] FlipBase     = 13'd4096;
  localparam logic [1:0]      GraceReports = 2'd2;

  // Input item kinds
  localparam logic KindSample    = 1'b0;
  localparam logic KindPenDetect = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MEASURE_EN  = 3'd0,
    REG_SPREAD_X    = 3'd1,
    REG_SPREAD_Y    = 3'd2,
    REG_JUMP_RADIUS = 3'd3,
    REG_EDGE_OFFSET = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EV_POINT = 2'd0,
    EV_LIFT  = 2'd1,
    EV_START = 2'd2
  } event_e;

  typedef struct packed {
    logic               measure_en;
    logic [SampleW-1:0] spread_x;
    logic [SampleW-1:0] spread_y;
    logic [RadiusW-1:0] radius;
    logic [OffsetW-1:0] offset;
  } cfg_t;

  // Control bits of a finished set or a pen-detect request
  typedef struct packed {
    logic is_pen;
    logic failed;
    logic pen_bit;
  } set_ctl_t;

  // Averaged set on its way to the decision stage
  typedef struct packed {
    logic               is_pen;
    logic               good;
    logic               pen_bit;
    logic [SampleW-1:0] avg_x;
    logic [SampleW-1:0] avg_y;
  } avg_t;

  typedef struct packed {
    logic res_valid;
    logic commit;
    logic pen_down;
  } dec_status_t;

endpackage

`default_nettype wire

>>> rtl/tsq_channels_if.sv
`default_nettype none

interface tsq_sample_if import tsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SampleW-1:0] x_sample;
  logic [SampleW-1:0] y_sample;
  logic               pen_bit;
  logic               read_error;

  modport source (output valid, kind, x_sample, y_sample, pen_bit, read_error,
                  input ready);
  modport sink   (input valid, kind, x_sample, y_sample, pen_bit, read_error,
                  output ready);
endinterface

interface tsq_event_if import tsq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             event_res;
  logic signed [PosW-1:0] x_pos;
  logic signed [PosW-1:0] y_pos;
  logic                   touching;

  modport source (output valid, event_res, x_pos, y_pos, touching, input ready);
  modport sink   (input valid, event_res, x_pos, y_pos, touching, output ready);
endinterface

interface tsq_cfg_if import tsq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tsq_accum.sv
`default_nettype none

module tsq_accum import tsq_pkg::*; #(
  parameter int unsigned SamplesPerPoint = SamplesPerPointDef,
  localparam int unsigned SumW = SampleW + $clog2(SamplesPerPoint)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [SampleW-1:0] x_i,
  input  logic [SampleW-1:0] y_i,
  input  logic               pen_i,
  input  logic               err_i,
  input  logic               take_i,
  output logic               set_valid_o,
  output set_ctl_t           set_ctl_o,
  output logic [SumW-1:0]    sum_x_o,
  output logic [SumW-1:0]    sum_y_o,
  output logic [SampleW-1:0] min_x_o,
  output logic [SampleW-1:0] max_x_o,
  output logic [SampleW-1:0] min_y_o,
  output logic [SampleW-1:0] max_y_o
);

  localparam int unsigned CntW = (SamplesPerPoint > 1) ? $clog2(SamplesPerPoint) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(SamplesPerPoint - 1);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               failed_q, failed_d;
  logic               last_pen_q, last_pen_d;
  logic [SumW-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [SampleW-1:0] min_x_q, min_x_d, max_x_q, max_x_d;
  logic [SampleW-1:0] min_y_q, min_y_d, max_y_q, max_y_d;
  logic               set_valid_q;
  set_ctl_t           set_ctl_q;
  logic [SumW-1:0]    out_sum_x_q, out_sum_y_q;
  logic [SampleW-1:0] out_min_x_q, out_max_x_q, out_min_y_q, out_max_y_q;

  logic accept, is_sample, first, set_done, emit;

  assign in_ready_o = !set_valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (kind_i == KindSample);
  assign first      = (cnt_q == '0);
  assign set_done   = (cnt_q == LastCnt);
  assign emit       = accept && (!is_sample || set_done);

  // Fold the sample into the running set; once failed the values no longer matter
  always_comb begin
    failed_d   = err_i || failed_q;
    last_pen_d = failed_d ? last_pen_q : pen_i;
    cnt_d      = set_done ? '0 : cnt_q + CntW'(1);
    if (first) begin
      sum_x_d = SumW'(x_i);
      sum_y_d = SumW'(y_i);
      min_x_d = x_i;
      max_x_d = x_i;
      min_y_d = y_i;
      max_y_d = y_i;
    end else begin
      sum_x_d = sum_x_q + SumW'(x_i);
      sum_y_d = sum_y_q + SumW'(y_i);
      min_x_d = (x_i < min_x_q) ? x_i : min_x_q;
      max_x_d = (x_i > max_x_q) ? x_i : max_x_q;
      min_y_d = (y_i < min_y_q) ? y_i : min_y_q;
      max_y_d = (y_i > max_y_q) ? y_i : max_y_q;
    end
  end

  // Set control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      failed_q    <= 1'b0;
      last_pen_q  <= 1'b1;
      set_valid_q <= 1'b0;
    end else begin
      if (accept && is_sample) begin
        cnt_q      <= cnt_d;
        failed_q   <= set_done ? 1'b0 : failed_d;
        last_pen_q <= last_pen_d;
      end
      if (emit) begin
        set_valid_q <= 1'b1;
      end else if (take_i) begin
        set_valid_q <= 1'b0;
      end
    end
  end

  // Running values and the finished-set register
  always_ff @(posedge clk_i) begin
    if (accept && is_sample) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      min_x_q <= min_x_d;
      max_x_q <= max_x_d;
      min_y_q <= min_y_d;
      max_y_q <= max_y_d;
    end
    if (emit) begin
      set_ctl_q   <= '{is_pen: !is_sample, failed: failed_d, pen_bit: last_pen_d};
      out_sum_x_q <= sum_x_d;
      out_sum_y_q <= sum_y_d;
      out_min_x_q <= min_x_d;
      out_max_x_q <= max_x_d;
      out_min_y_q <= min_y_d;
      out_max_y_q <= max_y_d;
    end
  end

  assign set_valid_o = set_valid_q;
  assign set_ctl_o   = set_ctl_q;
  assign sum_x_o     = out_sum_x_q;
  assign sum_y_o     = out_sum_y_q;
  assign min_x_o     = out_min_x_q;
  assign max_x_o     = out_max_x_q;
  assign min_y_o     = out_min_y_q;
  assign max_y_o     = out_max_y_q;

endmodule

`default_nettype wire

>>> rtl/tsq_average.sv
`default_nettype none

module tsq_average import tsq_pkg::*; #(
  parameter int unsigned SamplesPerPoint = SamplesPerPointDef,
  localparam int unsigned SumW = SampleW + $clog2(SamplesPerPoint)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               set_valid_i,
  output logic               take_o,
  input  set_ctl_t           set_ctl_i,
  input  logic [SumW-1:0]    sum_x_i,
  input  logic [SumW-1:0]    sum_y_i,
  input  logic [SampleW-1:0] min_x_i,
  input  logic [SampleW-1:0] max_x_i,
  input  logic [SampleW-1:0] min_y_i,
  input  logic [SampleW-1:0] max_y_i,
  input  logic               take_i,
  output logic               avg_valid_o,
  output avg_t               avg_o
);

  // Divide by the set size as a multiply by a rounded-up reciprocal; the shift
  // is wide enough that the quotient is exact for every reachable sum
  localparam int unsigned ShiftW = SumW + $clog2(SamplesPerPoint);
  localparam int unsigned MultW  = ShiftW + 1;
  localparam int unsigned ProdW  = SumW + MultW;
  localparam longint unsigned RecipL =
    ((longint'(1) << ShiftW) + SamplesPerPoint - 1) / SamplesPerPoint;
  localparam logic [MultW-1:0] Recip  = MultW'(RecipL);
  localparam logic [SumW-1:0]  MinSum = SumW'(SamplesPerPoint);

  logic [ProdW-1:0]   prod_x, prod_y;
  logic [SampleW-1:0] spread_x, spread_y;
  logic               good;
  logic               avg_valid_q;
  avg_t               avg_q;

  assign prod_x   = ProdW'(sum_x_i) * ProdW'(Recip);
  assign prod_y   = ProdW'(sum_y_i) * ProdW'(Recip);
  assign spread_x = max_x_i - min_x_i;
  assign spread_y = max_y_i - min_y_i;

  // A zero average is the same as a sum below the set size
  assign good = !set_ctl_i.failed
             && (spread_x <= cfg_i.spread_x) && (spread_y <= cfg_i.spread_y)
             && (sum_x_i >= MinSum) && (sum_y_i >= MinSum);

  assign take_o = !avg_valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_valid_q <= 1'b0;
    end else if (take_o) begin
      avg_valid_q <= set_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && set_valid_i) begin
      avg_q <= '{is_pen:  set_ctl_i.is_pen,
                 good:    good,
                 pen_bit: set_ctl_i.pen_bit,
                 avg_x:   prod_x[ShiftW +: SampleW],
                 avg_y:   prod_y[ShiftW +: SampleW]};
    end
  end

  assign avg_valid_o = avg_valid_q;
  assign avg_o       = avg_q;

endmodule

`default_nettype wire

>>> rtl/tsq_decide.sv
`default_nettype none

module tsq_decide import tsq_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   avg_valid_i,
  input  avg_t                   avg_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output event_e                 event_res_o,
  output logic signed [PosW-1:0] x_pos_o,
  output logic signed [PosW-1:0] y_pos_o,
  output logic                   touching_o,
  output dec_status_t            status_o
);

  logic               pen_down_q, pen_down_d;
  logic               prev_valid_q, prev_valid_d;
  logic [SampleW-1:0] prev_x_q, prev_y_q;
  logic [1:0]         reports_left_q, reports_left_d;
  logic               out_valid_q;
  event_e             event_q, event_d;
  logic [PosW-1:0]    x_pos_q, x_pos_d, y_pos_q, y_pos_d;
  logic               touching_q, touching_d;

  logic [SampleW-1:0]   dx, dy;
  logic [2*RadiusW-1:0] sq_x, sq_y, sq_r;
  logic [2*RadiusW:0]   dist_sq;
  logic                 near, close, keep, accept_pt, res, out_free, commit;

  // Distance to the last point; a move of a full radius step or more on
  // either axis is already out of reach, so only the low bits get squared
  assign dx = (avg_i.avg_x > prev_x_q) ? avg_i.avg_x - prev_x_q : prev_x_q - avg_i.avg_x;
  assign dy = (avg_i.avg_y > prev_y_q) ? avg_i.avg_y - prev_y_q : prev_y_q - avg_i.avg_y;
  assign near    = (dx[SampleW-1:RadiusW] == '0) && (dy[SampleW-1:RadiusW] == '0);
  assign sq_x    = dx[RadiusW-1:0] * dx[RadiusW-1:0];
  assign sq_y    = dy[RadiusW-1:0] * dy[RadiusW-1:0];
  assign sq_r    = cfg_i.radius * cfg_i.radius;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign close   = near && (dist_sq < {1'b0, sq_r});

  assign keep      = avg_i.pen_bit || (reports_left_q >= GraceReports);
  assign accept_pt = keep && avg_i.good && (!prev_valid_q || close);

  // Decide the request's outcome and the next pen state
  always_comb begin
    res            = 1'b0;
    event_d        = EV_POINT;
    x_pos_d        = '0;
    y_pos_d        = '0;
    touching_d     = 1'b0;
    pen_down_d     = pen_down_q;
    prev_valid_d   = prev_valid_q;
    reports_left_d = reports_left_q;
    if (avg_i.is_pen) begin
      if (cfg_i.measure_en && !pen_down_q) begin
        res          = 1'b1;
        event_d      = EV_START;
        pen_down_d   = 1'b1;
        prev_valid_d = 1'b0;
      end
    end else if (keep) begin
      if (reports_left_q != 2'd0) begin
        reports_left_d = reports_left_q - 2'd1;
      end
      if (accept_pt) begin
        res          = 1'b1;
        prev_valid_d = 1'b1;
        x_pos_d      = PosW'(avg_i.avg_x) - PosW'(cfg_i.offset);
        y_pos_d      = FlipBase - PosW'(avg_i.avg_y) - PosW'(cfg_i.offset);
        touching_d   = 1'b1;
      end
    end else begin
      reports_left_d = GraceReports;
      if (pen_down_q) begin
        res        = 1'b1;
        event_d    = EV_LIFT;
        pen_down_d = 1'b0;
      end
    end
  end

  // Retire a request unless it needs the output register and that is still full
  assign out_free = !out_valid_q || out_ready_i;
  assign commit   = avg_valid_i && (!res || out_free);
  assign take_o   = commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_down_q     <= 1'b0;
      prev_valid_q   <= 1'b0;
      reports_left_q <= GraceReports;
      out_valid_q    <= 1'b0;
    end else begin
      if (commit) begin
        pen_down_q     <= pen_down_d;
        prev_valid_q   <= prev_valid_d;
        reports_left_q <= reports_left_d;
      end
      if (commit && res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Last point and the result register
  always_ff @(posedge clk_i) begin
    if (commit && accept_pt && !avg_i.is_pen) begin
      prev_x_q <= avg_i.avg_x;
      prev_y_q <= avg_i.avg_y;
    end
    if (commit && res) begin
      event_q    <= event_d;
      x_pos_q    <= x_pos_d;
      y_pos_q    <= y_pos_d;
      touching_q <= touching_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;
  assign x_pos_o     = x_pos_q;
  assign y_pos_o     = y_pos_q;
  assign touching_o  = touching_q;
  assign status_o    = '{res_valid: avg_valid_i && res, commit: commit, pen_down: pen_down_q};

endmodule

`default_nettype wire

>>> rtl/touch_sample_qualifier_unit.sv
// Channel    Dir   Handshake      Payload
// sample_ch  in    valid/ready    kind, x_sample, y_sample, pen_bit, read_error
// event_ch   out   valid/ready    event_res, x_pos, y_pos, touching
// cfg_ch     in    valid/ready    index, data (ready always high)
//
// One request per cycle is taken unless the set register is full and not taken; the
// request that causes a result passes the set register, average register and result register.
// The average stage multiplies by a constant reciprocal; the decision stage
// holds the pen state, the last point and the grace count.
// Reset clears all control state; no clearing pass is needed.
// A stalled output holds only requests that need the result register;
// others still retire, so the input keeps flowing.
`default_nettype none
`include "touch_sample_qualifier_unit_assert.svh"

module touch_sample_qualifier_unit import tsq_pkg::*; #(
  parameter int unsigned SamplesPerPoint = SamplesPerPointDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsq_sample_if.sink  sample_ch,
  tsq_event_if.source event_ch,
  tsq_cfg_if.sink     cfg_ch
);

  localparam int unsigned SumW = SampleW + $clog2(SamplesPerPoint);

  cfg_t               cfg_q;
  logic               set_valid, avg_take, avg_valid, dec_take;
  set_ctl_t           set_ctl;
  logic [SumW-1:0]    sum_x, sum_y;
  logic [SampleW-1:0] min_x, max_x, min_y, max_y;
  avg_t               avg;
  event_e             event_res;
  dec_status_t        dec_status;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{measure_en: MeasureEnRst, spread_x: SpreadLimitRst,
                 spread_y: SpreadLimitRst, radius: JumpRadiusRst,
                 offset: EdgeOffsetRst};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MEASURE_EN:  cfg_q.measure_en <= cfg_ch.data[0];
        REG_SPREAD_X:    cfg_q.spread_x   <= cfg_ch.data[SampleW-1:0];
        REG_SPREAD_Y:    cfg_q.spread_y   <= cfg_ch.data[SampleW-1:0];
        REG_JUMP_RADIUS: cfg_q.radius     <= cfg_ch.data[RadiusW-1:0];
        REG_EDGE_OFFSET: cfg_q.offset     <= cfg_ch.data[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  tsq_accum #(.SamplesPerPoint(SamplesPerPoint)) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_ch.valid),
    .in_ready_o  (sample_ch.ready),
    .kind_i      (sample_ch.kind),
    .x_i         (sample_ch.x_sample),
    .y_i         (sample_ch.y_sample),
    .pen_i       (sample_ch.pen_bit),
    .err_i       (sample_ch.read_error),
    .take_i      (avg_take),
    .set_valid_o (set_valid),
    .set_ctl_o   (set_ctl),
    .sum_x_o     (sum_x),
    .sum_y_o     (sum_y),
    .min_x_o     (min_x),
    .max_x_o     (max_x),
    .min_y_o     (min_y),
    .max_y_o     (max_y)
  );

  tsq_average #(.SamplesPerPoint(SamplesPerPoint)) u_average (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .set_valid_i (set_valid),
    .take_o      (avg_take),
    .set_ctl_i   (set_ctl),
    .sum_x_i     (sum_x),
    .sum_y_i     (sum_y),
    .min_x_i     (min_x),
    .max_x_i     (max_x),
    .min_y_i     (min_y),
    .max_y_i     (max_y),
    .take_i      (dec_take),
    .avg_valid_o (avg_valid),
    .avg_o       (avg)
  );

  tsq_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avg_valid_i (avg_valid),
    .avg_i       (avg),
    .take_o      (dec_take),
    .out_valid_o (event_ch.valid),
    .out_ready_i (event_ch.ready),
    .event_res_o (event_res),
    .x_pos_o     (event_ch.x_pos),
    .y_pos_o     (event_ch.y_pos),
    .touching_o  (event_ch.touching),
    .status_o    (dec_status)
  );

  assign event_ch.event_res = event_res;

  // Checks
  `TSQ_ASSERT_NXT(a_stalled_result_held,
    dec_status.res_valid && event_ch.valid && !event_ch.ready,
    avg_valid && !dec_status.commit || avg_valid,
    "result request lost while output stalled")
  `TSQ_ASSERT_IMP(a_pen_down_reports_start, $rose(dec_status.pen_down),
    event_ch.valid && (event_ch.event_res == EV_START),
    "pen went down without a measuring-started result")
  `TSQ_ASSERT_IMP(a_touching_only_on_point, event_ch.valid,
    event_ch.touching == (event_ch.event_res == EV_POINT),
    "touching flag does not match the result kind")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench import tsq_pkg::*;;

  localparam int unsigned SetSize      = SamplesPerPointDef;
  localparam int unsigned SampleMax    = (1 << SampleW) - 1;
  localparam int unsigned SettleCycles = 8;

  typedef struct {
    event_e                 ev;
    logic signed [PosW-1:0] x_pos;
    logic signed [PosW-1:0] y_pos;
    logic                   touching;
  } touch_event_t;

  logic clk_i;
  logic rst_ni;

  tsq_sample_if sample_ch ();
  tsq_event_if  event_ch ();
  tsq_cfg_if    cfg_ch ();

  touch_sample_qualifier_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_ch(sample_ch),
    .event_ch (event_ch),
    .cfg_ch   (cfg_ch)
  );

  // Register shadow
  logic        cfg_measure_en;
  int unsigned cfg_spread_x, cfg_spread_y, cfg_radius, cfg_offset;

  // Qualifier state: pen, set in progress, last point, grace count
  logic        pen_is_down, set_bad, held_pen, last_known;
  int unsigned set_count, acc_x, acc_y, lo_x, hi_x, lo_y, hi_y;
  int unsigned last_x, last_y, grace_left;

  touch_event_t pending_events[$];
  int unsigned  mismatches   = 0;
  int unsigned  samples_sent = 0;
  bit           steady_flow  = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Set accumulation cleared after each completed set
  task automatic clear_set();
    set_count = 0;
    acc_x     = 0;
    acc_y     = 0;
    lo_x      = 0;
    hi_x      = 0;
    lo_y      = 0;
    hi_y      = 0;
    set_bad   = 1'b0;
  endtask

  task automatic reset_tracker();
    cfg_measure_en = MeasureEnRst;
    cfg_spread_x   = 32'(SpreadLimitRst);
    cfg_spread_y   = 32'(SpreadLimitRst);
    cfg_radius     = 32'(JumpRadiusRst);
    cfg_offset     = 32'(EdgeOffsetRst);
    pen_is_down    = 1'b0;
    clear_set();
    held_pen       = 1'b1;
    last_x         = 0;
    last_y         = 0;
    last_known     = 1'b0;
    grace_left     = 32'(GraceReports);
  endtask

  task automatic push_event(input event_e ev, input logic [PosW-1:0] x, y, input logic t);
    touch_event_t e;
    e.ev       = ev;
    e.x_pos    = x;
    e.y_pos    = y;
    e.touching = t;
    pending_events.push_back(e);
  endtask

  // Advance the qualifier by one accepted request and queue any event it causes
  task automatic qualify_request(input logic kind, input logic [SampleW-1:0] xs, ys,
                                 input logic pen, err);
    int unsigned avg_x, avg_y, dist_x, dist_y;
    bit          set_good, take_point;
    if (kind == KindPenDetect) begin
      // act on pen detect only while enabled and the pen is up
      if (cfg_measure_en && !pen_is_down) begin
        pen_is_down = 1'b1;
        last_known  = 1'b0;
        push_event(EV_START, '0, '0, 1'b0);
      end
    end else begin
      // a failed read spoils the rest of the set
      if (err || set_bad) begin
        set_bad = 1'b1;
      end else begin
        held_pen = pen;
        if (set_count == 0) begin
          lo_x = 32'(xs);
          hi_x = 32'(xs);
          lo_y = 32'(ys);
          hi_y = 32'(ys);
        end else begin
          if (xs < lo_x) lo_x = 32'(xs);
          if (xs > hi_x) hi_x = 32'(xs);
          if (ys < lo_y) lo_y = 32'(ys);
          if (ys > hi_y) hi_y = 32'(ys);
        end
        acc_x += 32'(xs);
        acc_y += 32'(ys);
      end
      set_count++;
      if (set_count == SetSize) begin
        avg_x    = acc_x / SetSize;
        avg_y    = acc_y / SetSize;
        set_good = !set_bad && (hi_x - lo_x) <= cfg_spread_x &&
                   (hi_y - lo_y) <= cfg_spread_y && avg_x > 0 && avg_y > 0;
        clear_set();
        if (held_pen || grace_left >= GraceReports) begin
          // keep touch: report the point if close enough to the last one
          take_point = 1'b0;
          if (set_good) begin
            if (!last_known) begin
              take_point = 1'b1;
            end else begin
              dist_x     = (avg_x > last_x) ? avg_x - last_x : last_x - avg_x;
              dist_y     = (avg_y > last_y) ? avg_y - last_y : last_y - avg_y;
              take_point = (dist_x * dist_x + dist_y * dist_y) < cfg_radius * cfg_radius;
            end
          end
          if (grace_left > 0) grace_left--;
          if (take_point) begin
            last_x     = avg_x;
            last_y     = avg_y;
            last_known = 1'b1;
            push_event(EV_POINT, PosW'(avg_x - cfg_offset),
                       PosW'(FlipBase - avg_y - cfg_offset), 1'b1);
          end
        end else begin
          // lift: reported once, only if the pen was down
          grace_left = 32'(GraceReports);
          if (pen_is_down) begin
            pen_is_down = 1'b0;
            push_event(EV_LIFT, '0, '0, 1'b0);
          end
        end
      end
    end
  endtask

  // Track accepted requests
  always @(posedge clk_i) begin
    if (rst_ni && sample_ch.valid && sample_ch.ready) begin
      qualify_request(sample_ch.kind, sample_ch.x_sample, sample_ch.y_sample,
                      sample_ch.pen_bit, sample_ch.read_error);
    end
  end

  // Track register writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_e'(cfg_ch.index))
        REG_MEASURE_EN:  cfg_measure_en = cfg_ch.data[0];
        REG_SPREAD_X:    cfg_spread_x   = 32'(cfg_ch.data[SampleW-1:0]);
        REG_SPREAD_Y:    cfg_spread_y   = 32'(cfg_ch.data[SampleW-1:0]);
        REG_JUMP_RADIUS: cfg_radius     = 32'(cfg_ch.data[RadiusW-1:0]);
        REG_EDGE_OFFSET: cfg_offset     = 32'(cfg_ch.data[OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  task automatic report_field(input string field, input logic [PosW-1:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Compare each delivered event with the oldest expected one
  always @(posedge clk_i) begin
    touch_event_t want;
    if (rst_ni && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event with nothing expected: event_res %0d x_pos %0d y_pos %0d",
                 $time, event_ch.event_res, event_ch.x_pos, event_ch.y_pos);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        report_field("event_res", PosW'(want.ev), PosW'(event_ch.event_res));
        report_field("x_pos", want.x_pos, event_ch.x_pos);
        report_field("y_pos", want.y_pos, event_ch.y_pos);
        report_field("touching", PosW'(want.touching), PosW'(event_ch.touching));
      end
    end
  end

  // Event sink: stall a random number of cycles before each event unless steady flow is set
  initial begin
    int unsigned stall;
    event_ch.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      event_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(event_ch.valid && event_ch.ready));
    end
  end

  // Send one request after a random gap; return at the edge that takes it
  task automatic send_request(input logic kind, input logic [SampleW-1:0] xs, ys,
                              input logic pen, err);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.kind       <= kind;
    sample_ch.x_sample   <= xs;
    sample_ch.y_sample   <= ys;
    sample_ch.pen_bit    <= pen;
    sample_ch.read_error <= err;
    do @(posedge clk_i); while (!sample_ch.ready);
    if (kind == KindSample) samples_sent++;
  endtask

  function automatic logic [SampleW-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(SampleMax)) return '1;
    return SampleW'(v);
  endfunction

  // One set of samples jittered upwards from a base point
  task automatic send_set(input int base_x, base_y, input int unsigned jitter,
                          input logic pen, input int unsigned err_odds);
    logic [SampleW-1:0] xs, ys;
    logic               err;
    for (int i = 0; i < SetSize; i++) begin
      xs  = clamp_sample(base_x + int'($urandom_range(0, jitter)));
      ys  = clamp_sample(base_y + int'($urandom_range(0, jitter)));
      err = (err_odds != 0) && ($urandom_range(1, err_odds) == 1);
      send_request(KindSample, xs, ys, pen, err);
    end
  endtask

  // Hold requests until every expected event has come and the pipeline is empty
  task automatic wait_until_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic apply_settings(input logic en, input int unsigned sx, sy, radius, offset);
    write_register(REG_MEASURE_EN, 32'(en));
    write_register(REG_SPREAD_X, sx);
    write_register(REG_SPREAD_Y, sy);
    write_register(REG_JUMP_RADIUS, radius);
    write_register(REG_EDGE_OFFSET, offset);
    cfg_ch.valid <= 1'b0;
  endtask

  // Pen goes down, the point wanders, then the pen lifts through the grace count
  task automatic draw_stroke();
    int          px, py;
    int unsigned jitter;
    px = int'($urandom_range(0, SampleMax));
    py = int'($urandom_range(0, SampleMax));
    if ($urandom_range(0, 3) != 0) begin
      send_request(KindPenDetect, SampleW'($urandom_range(0, SampleMax)),
                   SampleW'($urandom_range(0, SampleMax)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 6)) begin
      px     = int'(clamp_sample(px + int'($urandom_range(0, 16)) - 8));
      py     = int'(clamp_sample(py + int'($urandom_range(0, 16)) - 8));
      jitter = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 12);
      send_set(px, py, jitter, $urandom_range(0, 7) != 0, 12);
    end
    repeat ($urandom_range(0, 3)) send_set(px, py, $urandom_range(0, 12), 1'b0, 12);
  endtask

  task automatic draw_noise();
    repeat ($urandom_range(1, 4)) begin
      send_request(1'($urandom_range(0, 1)), SampleW'($urandom_range(0, SampleMax)),
                   SampleW'($urandom_range(0, SampleMax)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed_cases();
    // clean set while the pen is up still gives a point
    send_set(2000, 2100, 0, 1'b1, 0);
    // pen detect starts measuring; its sample fields are ignored
    send_request(KindPenDetect, 12'hfff, 12'hfff, 1'b1, 1'b1);
    // top corner after the restart is taken with no distance check
    send_set(SampleMax, SampleMax, 0, 1'b1, 0);
    // small move inside the radius
    send_set(4090, 4090, 0, 1'b1, 0);
    // failed read mid-set, an ignored pen detect inside it, pen bit from the good read
    send_request(KindSample, 12'd4090, 12'd4090, 1'b0, 1'b0);
    send_request(KindPenDetect, 12'd0, 12'd0, 1'b0, 1'b0);
    send_request(KindSample, 12'd4090, 12'd4090, 1'b1, 1'b1);
    send_request(KindSample, 12'd4090, 12'd4090, 1'b1, 1'b0);
    send_request(KindPenDetect, 12'd0, 12'd0, 1'b0, 1'b0);
    // average truncates to zero
    send_request(KindSample, 12'd0, 12'd1000, 1'b1, 1'b0);
    send_request(KindSample, 12'd0, 12'd1000, 1'b1, 1'b0);
    send_request(KindSample, 12'd2, 12'd1000, 1'b1, 1'b0);
    // x spread one above the limit
    send_request(KindSample, 12'd1000, 12'd1000, 1'b1, 1'b0);
    send_request(KindSample, 12'd1251, 12'd1000, 1'b1, 1'b0);
    send_request(KindSample, 12'd1000, 12'd1000, 1'b1, 1'b0);
    // pen bit low once grace is spent
    send_set(1, 1, 0, 1'b0, 0);
  endtask

  task automatic exercise_setting(input logic en, input int unsigned sx, sy, radius, offset);
    wait_until_drained();
    apply_settings(en, sx, sy, radius, offset);
    steady_flow = 1'($urandom_range(0, 1));
    repeat (2) draw_stroke();
    draw_noise();
  endtask

  task automatic test_register_extremes();
    exercise_setting(1'b0, 0, 0, 0, 0);
    exercise_setting(1'b1, SampleMax, SampleMax, (1 << RadiusW) - 1, (1 << OffsetW) - 1);
    exercise_setting(1'b1, SampleMax, 0, (1 << RadiusW) - 1, 0);
    exercise_setting(1'b0, 0, SampleMax, 1, (1 << OffsetW) - 1);
    exercise_setting(MeasureEnRst, 32'(SpreadLimitRst), 32'(SpreadLimitRst),
                     32'(JumpRadiusRst), 32'(EdgeOffsetRst));
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    bit          reprogrammed;
    target       = samples_sent + 200;
    reprogrammed = 1'b0;
    while (samples_sent < target) begin
      // halfway: hold the sender until all events are in, then reprogram
      if (!reprogrammed && samples_sent + 100 >= target) begin
        wait_until_drained();
        apply_settings($urandom_range(0, 4) != 0, $urandom_range(0, SampleMax),
                       $urandom_range(0, SampleMax), $urandom_range(0, (1 << RadiusW) - 1),
                       $urandom_range(0, (1 << OffsetW) - 1));
        reprogrammed = 1'b1;
      end
      steady_flow = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 2) draw_noise();
      else draw_stroke();
    end
  endtask

  initial begin
    rst_ni               <= 1'b0;
    sample_ch.valid      <= 1'b0;
    sample_ch.kind       <= KindSample;
    sample_ch.x_sample   <= '0;
    sample_ch.y_sample   <= '0;
    sample_ch.pen_bit    <= 1'b0;
    sample_ch.read_error <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_MEASURE_EN;
    cfg_ch.data          <= '0;
    reset_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_register_extremes();
    test_random_traffic();

    steady_flow = 1'b0;
    wait_until_drained();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
